@@ rtl/dcw_pkg.sv @@
// Shared types, status codes and lookup functions for the date check block.
package dcw_pkg;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_YEAR  = 2'd1;
    localparam logic [1:0] ST_BAD_MONTH = 2'd2;
    localparam logic [1:0] ST_BAD_DAY   = 2'd3;

    localparam logic [15:0] MIN_YEAR = 16'd1600;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    // floor(x / 100) ~ (x * 1310) >> 17, never high, at most one low for 16-bit x
    localparam int          DIV100_SHIFT = 17;
    localparam logic [10:0] DIV100_MUL   = 11'd1310;
    localparam int          PROD_W       = 27;
    localparam int          CENT_W       = 10;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] weekday;
    } out_word_t;

    // After range checks and start of the divide by 100
    typedef struct packed {
        logic [5:0]        day;
        logic [3:0]        mz;      // month, Jan/Feb shifted to 13/14
        logic [15:0]       yz;      // year, decremented for Jan/Feb
        logic [PROD_W-1:0] prod;
        logic [1:0]        status;
    } s1_word_t;

    // After century split
    typedef struct packed {
        logic [5:0]        day;
        logic [3:0]        mz;
        logic [CENT_W-1:0] cent;
        logic [6:0]        yoc;     // year of century
        logic              leap;    // leap flag, meaningful for February only
        logic [1:0]        status;
    } s2_word_t;

    // After day check and Zeller sum
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] hsum;
    } s3_word_t;

    // Days in month, indexed by the shifted month (13 = Jan, 14 = Feb)
    function automatic logic [4:0] month_days(input logic [3:0] mz, input logic leap);
        logic [4:0] len;
        begin
            case (mz)
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                4'd14:                   len = leap ? 5'd29 : 5'd28;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // floor(13 * (m + 1) / 5) for the shifted month 3..14
    function automatic logic [5:0] zel_month(input logic [3:0] mz);
        logic [5:0] t;
        begin
            case (mz)
                4'd3:    t = 6'd10;
                4'd4:    t = 6'd13;
                4'd5:    t = 6'd15;
                4'd6:    t = 6'd18;
                4'd7:    t = 6'd20;
                4'd8:    t = 6'd23;
                4'd9:    t = 6'd26;
                4'd10:   t = 6'd28;
                4'd11:   t = 6'd31;
                4'd12:   t = 6'd33;
                4'd13:   t = 6'd36;
                4'd14:   t = 6'd39;
                default: t = 6'd0;
            endcase
            return t;
        end
    endfunction

endpackage

@@ rtl/dcw_check.sv @@
// Stage 1: year and month checks, Jan/Feb shift, reciprocal multiply for /100.
module dcw_check import dcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output s1_word_t out_data
);

    logic       valid_reg;
    s1_word_t   data_reg;
    s1_word_t   data_next;
    logic       load;
    logic       early;
    logic [15:0] yz;

    assign in_stall  = valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // January and February count as months 13 and 14 of the year before
    always_comb
    begin
        early          = (in_data.month == MONTH_JAN) || (in_data.month == MONTH_FEB);
        yz             = early ? (in_data.year - 16'd1) : in_data.year;
        data_next.day  = in_data.day;
        data_next.mz   = early ? (in_data.month + 4'd12) : in_data.month;
        data_next.yz   = yz;
        data_next.prod = {11'd0, yz} * {16'd0, DIV100_MUL};
        if (in_data.year < MIN_YEAR)
            data_next.status = ST_BAD_YEAR;
        else if ((in_data.month == 4'd0) || (in_data.month > MONTH_DEC))
            data_next.status = ST_BAD_MONTH;
        else
            data_next.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

@@ rtl/dcw_split.sv @@
// Stage 2: finish century / year-of-century split and derive the leap flag.
module dcw_split import dcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  s1_word_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output s2_word_t out_data
);

    logic              valid_reg;
    s2_word_t          data_reg;
    s2_word_t          data_next;
    logic              load;
    logic [CENT_W-1:0] q;
    logic [16:0]       qx100;
    logic [16:0]       rem_wide;
    logic [7:0]        rem;

    assign in_stall  = valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Estimate may be one low; remainder stays below 200, one correction step
    always_comb
    begin
        q        = in_data.prod[DIV100_SHIFT +: CENT_W];
        qx100    = {1'b0, q, 6'd0} + {2'b0, q, 5'd0} + {5'd0, q, 2'd0};
        rem_wide = {1'b0, in_data.yz} - qx100;
        rem      = rem_wide[7:0];
        data_next.day    = in_data.day;
        data_next.mz     = in_data.mz;
        data_next.status = in_data.status;
        if (rem >= 8'd100)
        begin
            data_next.cent = q + {{(CENT_W-1){1'b0}}, 1'b1};
            data_next.yoc  = 7'(rem - 8'd100);
        end
        else
        begin
            data_next.cent = q;
            data_next.yoc  = rem[6:0];
        end
        // Leap test on yz + 1: y%100 == 0 means yz%100 == 99, then y%400 needs cent+1 %4 == 0
        data_next.leap = (in_data.yz[1:0] == 2'b11) &&
                         ((data_next.yoc != 7'd99) || (data_next.cent[1:0] == 2'b11));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

@@ rtl/dcw_zsum.sv @@
// Stage 3: day-of-month check and Zeller congruence sum.
module dcw_zsum import dcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  s2_word_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output s3_word_t out_data
);

    logic       valid_reg;
    s3_word_t   data_reg;
    s3_word_t   data_next;
    logic       load;
    logic [4:0] mlen;

    assign in_stall  = valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        mlen = month_days(in_data.mz, in_data.leap);
        // Earlier failures win
        if (in_data.status != ST_OK)
            data_next.status = in_data.status;
        else if ((in_data.day == 6'd0) || (in_data.day > {1'b0, mlen}))
            data_next.status = ST_BAD_DAY;
        else
            data_next.status = ST_OK;
        // h = d + 13(m+1)/5 + k + k/4 + c/4 + 5c, below 3700
        data_next.hsum = 12'(in_data.day)
                       + 12'(zel_month(in_data.mz))
                       + 12'(in_data.yoc)
                       + 12'(in_data.yoc[6:2])
                       + 12'(in_data.cent[CENT_W-1:2])
                       + 12'({in_data.cent, 2'b00})
                       + 12'(in_data.cent);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

@@ rtl/dcw_mod7.sv @@
// Stage 4: reduce the Zeller sum mod 7 and hold the output word.
module dcw_mod7 import dcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  s3_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic       valid_reg;
    out_word_t  data_reg;
    out_word_t  data_next;
    logic       load;
    logic [4:0] fold1;
    logic [3:0] fold2;
    logic [2:0] wd;

    assign in_stall  = valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // 8 == 1 mod 7: sum octal digits twice, then one subtract
    always_comb
    begin
        fold1 = 5'(in_data.hsum[2:0]) + 5'(in_data.hsum[5:3])
              + 5'(in_data.hsum[8:6]) + 5'(in_data.hsum[11:9]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
        wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
        data_next.status  = in_data.status;
        data_next.weekday = (in_data.status == ST_OK) ? wd : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

@@ rtl/date_check_and_weekday.sv @@
// Gregorian date check with Zeller weekday, four-stage pipeline top level.
// Each input word carries a day, month and year and produces exactly one output word
// with a status (0 ok, 1 year below 1600, 2 month outside 1..12, 3 day outside the
// month) and a weekday (0 Saturday through 6 Friday, 0 for any bad date). The block
// keeps no state. A word can enter every cycle while in_stall is low, and its result passes
// through one stage each for the range checks with a reciprocal multiply, the divide-by-100
// correction and leap test, the day check with the Zeller sum, and the mod-7 reduction
// into the output register. Each stage holds its word under stall and refills bubbles,
// so in_stall rises only when all four stages are full and out_stall is high.
module date_check_and_weekday import dcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic     s1_valid;
    logic     s1_stall;
    s1_word_t s1_data;
    logic     s2_valid;
    logic     s2_stall;
    s2_word_t s2_data;
    logic     s3_valid;
    logic     s3_stall;
    s3_word_t s3_data;

    dcw_check u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (s1_valid),
        .out_stall (s1_stall),
        .out_data  (s1_data)
    );

    dcw_split u_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_stall  (s1_stall),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_stall (s2_stall),
        .out_data  (s2_data)
    );

    dcw_zsum u_zsum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_stall  (s2_stall),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_stall (s3_stall),
        .out_data  (s3_data)
    );

    dcw_mod7 u_mod7
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_stall  (s3_stall),
        .in_data   (s3_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ rtl/dcw_checker.sv @@
// Port-level checks for the date check block, bound to the top level.
module dcw_checker import dcw_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    // A stalled output word stays and holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");

    // Input backs up only when the output is full and stalled
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // Bad dates carry weekday zero
    a_bad_wd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.weekday == 3'd0)
        else $error("nonzero weekday on bad date");

    // Weekday stays in 0..6
    a_wd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.weekday != 3'd7)
        else $error("weekday out of range");

endmodule

bind date_check_and_weekday dcw_checker u_dcw_checker (.*);
